### sv/bpc_pkg.sv
// Package for the barometer compensation pipeline: field widths, calibration
// register indexes, range limits and the truncating power-of-two divide.
// No dependencies.
package bpc_pkg;

  localparam int RAW_W   = 24;
  localparam int CAL_W   = 16;
  localparam int PRESS_W = 17;
  localparam int TEMP_W  = 15;
  localparam int CFG_IDX_W = 3;

  // calibration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_SENS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_OFF  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_TC    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_TC     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_TC    = 3'd5;

  localparam logic signed [18:0] TEMP_REF = 19'sd2000;
  localparam logic signed [19:0] TEMP_MIN = -20'sd4000;
  localparam logic signed [19:0] TEMP_MAX = 20'sd8500;
  localparam logic signed [63:0] PRESS_MAX = 64'sd131071;

  // signed divide by 2**k, rounding toward zero
  function automatic logic signed [63:0] sdiv_p2(input logic signed [63:0] x,
                                                 input int unsigned k);
    logic signed [63:0] bias;
    bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (x + bias) >>> k;
  endfunction

endpackage

### sv/bpc_sample_if.sv
// Input channel: one raw pressure / raw temperature word per handshake.
// Depends on bpc_pkg.
interface bpc_sample_if import bpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_pressure;
  logic [RAW_W-1:0] raw_temperature;

  modport source(output valid, raw_pressure, raw_temperature, input ready);
  modport sink(input valid, raw_pressure, raw_temperature, output ready);
endinterface

### sv/bpc_result_if.sv
// Output channel: one compensated pressure / temperature word per handshake.
// Depends on bpc_pkg.
interface bpc_result_if import bpc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [PRESS_W-1:0]       pressure;
  logic signed [TEMP_W-1:0] temperature;

  modport source(output valid, pressure, temperature, input ready);
  modport sink(input valid, pressure, temperature, output ready);
endinterface

### sv/baro_pressure_temp_compensation_top.sv
// Channel | dir | handshake     | payload
// sample  | in  | valid / ready | raw_pressure[23:0], raw_temperature[23:0]
// result  | out | valid / ready | pressure[16:0], temperature[14:0] signed
// cfg     | in  | cfg_we        | cfg_index[2:0], cfg_data[15:0]
// Nine register stages; one word per cycle unless the result side stalls.
// Stage 6 splits the 24 x 38 bit pressure product into two halves.
// Reset clears the stage valid bits and the calibration words.
// Each stage holds while the one after it is full and stalled, so a stall at
// the output only backs up as far as the first empty stage.
// Depends on bpc_pkg, bpc_sample_if, bpc_result_if.
module baro_pressure_temp_compensation_top import bpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CAL_W-1:0]     cfg_data,
  bpc_sample_if.sink           sample,
  bpc_result_if.source         result
);

  logic [CAL_W-1:0] pressure_sensitivity, pressure_offset, sens_temp_coeff;
  logic [CAL_W-1:0] offset_temp_coeff, reference_temperature, temp_coeff_of_temp;

  always_ff @(posedge clk) begin
    if (rst) begin
      pressure_sensitivity  <= '0;
      pressure_offset       <= '0;
      sens_temp_coeff       <= '0;
      offset_temp_coeff     <= '0;
      reference_temperature <= '0;
      temp_coeff_of_temp    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PRESS_SENS: pressure_sensitivity  <= cfg_data;
        REG_PRESS_OFF:  pressure_offset       <= cfg_data;
        REG_SENS_TC:    sens_temp_coeff       <= cfg_data;
        REG_OFF_TC:     offset_temp_coeff     <= cfg_data;
        REG_REF_TEMP:   reference_temperature <= cfg_data;
        REG_TEMP_TC:    temp_coeff_of_temp    <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage valid bits and advance enables
  logic [9:1]  vld;
  logic [10:1] en;

  always_comb begin
    en[10] = result.ready;
    for (int k = 9; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= sample.valid;
      for (int k = 2; k <= 9; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign sample.ready = en[1];
  assign result.valid = vld[9];

  // stage 1: temperature difference
  logic [RAW_W-1:0]   d1_1;
  logic signed [24:0] dt_1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      d1_1 <= sample.raw_pressure;
      dt_1 <= $signed({1'b0, sample.raw_temperature})
            - $signed({1'b0, reference_temperature, 8'b0});
    end
  end

  // stage 2: the four products with dT
  logic [RAW_W-1:0]   d1_2;
  logic signed [41:0] mt_2, mo_2, ms_2;
  logic [47:0]        dsq_2;
  logic signed [49:0] dsq_full;

  assign dsq_full = dt_1 * dt_1;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      d1_2  <= d1_1;
      mt_2  <= dt_1 * $signed({1'b0, temp_coeff_of_temp});
      mo_2  <= dt_1 * $signed({1'b0, offset_temp_coeff});
      ms_2  <= dt_1 * $signed({1'b0, sens_temp_coeff});
      dsq_2 <= dsq_full[47:0];
    end
  end

  // stage 3: first-order TEMP, OFF, SENS
  logic [RAW_W-1:0]   d1_3;
  logic signed [18:0] q_3, temp_3;
  logic signed [35:0] off_3;
  logic signed [34:0] sens_3;
  logic [16:0]        t2_3;
  logic signed [63:0] mt_div, mo_div, ms_div;

  always_comb begin
    mt_div = sdiv_p2(64'(mt_2), 23);
    mo_div = sdiv_p2(64'(mo_2), 7);
    ms_div = sdiv_p2(64'(ms_2), 8);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      d1_3   <= d1_2;
      q_3    <= $signed(mt_div[18:0]);
      temp_3 <= $signed(mt_div[18:0]) + TEMP_REF;
      off_3  <= $signed({4'b0, pressure_offset, 16'b0}) + $signed(mo_div[35:0]);
      sens_3 <= $signed({4'b0, pressure_sensitivity, 15'b0}) + $signed(ms_div[34:0]);
      t2_3   <= dsq_2[47:31];
    end
  end

  // stage 4: square of the temperature deficit, corrected TEMP
  logic [RAW_W-1:0]   d1_4;
  logic               low_4;
  logic [34:0]        sq_4;
  logic signed [19:0] temp_4;
  logic signed [35:0] off_4;
  logic signed [34:0] sens_4;
  logic signed [37:0] sq_full;

  assign sq_full = q_3 * q_3;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      d1_4   <= d1_3;
      low_4  <= q_3[18];
      sq_4   <= sq_full[34:0];
      temp_4 <= q_3[18] ? 20'(temp_3) - $signed({3'b0, t2_3}) : 20'(temp_3);
      off_4  <= off_3;
      sens_4 <= sens_3;
    end
  end

  // stage 5: second-order OFF and SENS, temperature clamp
  logic [RAW_W-1:0]         d1_5;
  logic signed [38:0]       off_5;
  logic signed [37:0]       sens_5;
  logic signed [TEMP_W-1:0] tc_5;
  logic [37:0]              sq5;

  assign sq5 = {1'b0, sq_4, 2'b0} + {3'b0, sq_4};

  always_ff @(posedge clk) begin
    if (en[5]) begin
      d1_5   <= d1_4;
      off_5  <= 39'(off_4) - (low_4 ? $signed({2'b0, sq5[37:1]}) : 39'sd0);
      sens_5 <= 38'(sens_4) - (low_4 ? $signed({2'b0, sq5[37:2]}) : 38'sd0);
      if (temp_4 < TEMP_MIN)      tc_5 <= TEMP_MIN[TEMP_W-1:0];
      else if (temp_4 > TEMP_MAX) tc_5 <= TEMP_MAX[TEMP_W-1:0];
      else                        tc_5 <= temp_4[TEMP_W-1:0];
    end
  end

  // stage 6: D1 * SENS as two partial products (low half unsigned)
  logic [42:0]              pl_6;
  logic signed [43:0]       ph_6;
  logic signed [38:0]       off_6;
  logic signed [TEMP_W-1:0] tc_6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      pl_6  <= d1_5 * sens_5[18:0];
      ph_6  <= $signed({1'b0, d1_5}) * $signed(sens_5[37:19]);
      off_6 <= off_5;
      tc_6  <= tc_5;
    end
  end

  // stage 7: recombine the product
  logic signed [62:0]       prod_7;
  logic signed [38:0]       off_7;
  logic signed [TEMP_W-1:0] tc_7;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      prod_7 <= $signed({ph_6, 19'b0}) + $signed({20'b0, pl_6});
      off_7  <= off_6;
      tc_7   <= tc_6;
    end
  end

  // stage 8: scale and subtract offset
  logic signed [41:0]       x_8;
  logic signed [TEMP_W-1:0] tc_8;
  logic signed [63:0]       prod_div;

  assign prod_div = sdiv_p2(64'(prod_7), 21);

  always_ff @(posedge clk) begin
    if (en[8]) begin
      x_8  <= $signed(prod_div[41:0]) - 42'(off_7);
      tc_8 <= tc_7;
    end
  end

  // stage 9: final scale and pressure clamp, output register
  logic signed [63:0] p_div;

  assign p_div = sdiv_p2(64'(x_8), 15);

  always_ff @(posedge clk) begin
    if (en[9]) begin
      if (p_div < 64'sd0)          result.pressure <= '0;
      else if (p_div > PRESS_MAX)  result.pressure <= PRESS_MAX[PRESS_W-1:0];
      else                         result.pressure <= p_div[PRESS_W-1:0];
      result.temperature <= tc_8;
    end
  end

  // a free first stage always takes a word
  a_ready_on_bubble: assert property (@(posedge clk) disable iff (rst)
    !vld[1] |-> sample.ready)
    else $error("input not ready with first stage empty");

  // a held stage 5 keeps its word
  a_stage5_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[5] && !en[5]) |=> (vld[5] && $stable(off_5) && $stable(sens_5)))
    else $error("stalled stage 5 lost its word");

  // negative pressure saturates to zero
  a_press_floor: assert property (@(posedge clk) disable iff (rst)
    (en[9] && vld[8] && p_div < 64'sd0) |=> (result.pressure == '0))
    else $error("negative pressure not clamped");

  // temperature stays in range
  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.temperature >= -15'sd4000 &&
                      result.temperature <= 15'sd8500))
    else $error("temperature out of range");

endmodule
